// ===== hdl/pbu_pkg.sv =====
// Package for particle_burst_update: field widths, register indexes, state type.
// Used by the top level and the generic RAM needs nothing from it.
package pbu_pkg;
    localparam int NumParticlesDef = 64;
    localparam int PosW  = 20;
    localparam int VelW  = 14;
    localparam int LifeW = 20;
    localparam int FullW = 22;
    localparam int MaxdW = 16;
    localparam int GradW = 9;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 22;

    localparam logic [CfgIdxW-1:0] RegEmitX = 2'd0;
    localparam logic [CfgIdxW-1:0] RegEmitY = 2'd1;
    localparam logic [CfgIdxW-1:0] RegFull  = 2'd2;
    localparam logic [CfgIdxW-1:0] RegMaxd  = 2'd3;

    localparam logic ReqLoad = 1'b0;
    localparam logic ReqTick = 1'b1;

    // Entry layout in the particle RAM: {life, vel_y, vel_x, pos_y, pos_x}
    localparam int EntryW = 2*PosW + 2*VelW + LifeW;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_LIFE, S_MULX, S_MULY, S_DIVX, S_DIVY,
        S_SQR, S_ISQ, S_DIVU, S_DIVV, S_EMIT
    } t_state;
endpackage

// ===== hdl/pbu_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module pbu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/particle_burst_update.sv =====
// particle_burst_update: a load word (tuser=0) writes one particle slot. A tick
// word (tuser=1) walks all NUM_PARTICLES slots in order, one result word per
// slot with tlast on the final slot; no input is taken until the walk ends. A
// live slot goes through two 45-step bit-serial divisions (by the lifetime and
// the distance registers), a 21-step square root, and the read, position update
// by reciprocal multiply, squares and emit. A dead slot goes from the life check
// straight to emit. A stalled result word holds the walk in place.
// The particle table sits in one RAM; alive bits are flip-flops cleared by reset.
module particle_burst_update
    import pbu_pkg::*;
#(
    parameter int NUM_PARTICLES = NumParticlesDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // slot[5:0], vel_x[19:6], vel_y[33:20], life_us[53:34], elapsed_us[73:54], zero fill
    input  logic [79:0]         s_axis_tdata,
    input  logic                s_axis_tuser,   // req_type
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_slot[5:0], alive[6], pos_x[26:7], pos_y[46:27], grad_u[55:47], grad_v[64:56]
    output logic [71:0]         m_axis_tdata,
    output logic                m_axis_tlast
);
    localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int DivW = 45;
    localparam int ProdW = VelW + LifeW + 1;
    // ceil(2^41 / 15625): exact quotient for any 27-bit dividend
    localparam logic [27:0] RecipM = 28'd140737489;

    t_state r_state, n_state;

    logic signed [PosW-1:0] r_emit_x, r_emit_y;
    logic [FullW-1:0] r_full;
    logic [MaxdW-1:0] r_maxd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_x <= '0;
            r_emit_y <= '0;
            r_full   <= FullW'(3000000);
            r_maxd   <= MaxdW'(150);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegEmitX: r_emit_x <= i_cfg_data[PosW-1:0];
                RegEmitY: r_emit_y <= i_cfg_data[PosW-1:0];
                RegFull:  r_full   <= i_cfg_data[FullW-1:0];
                RegMaxd:  r_maxd   <= i_cfg_data[MaxdW-1:0];
                default: ;
            endcase
        end
    end

    logic [5:0] in_slot;
    logic signed [VelW-1:0] in_vx, in_vy;
    logic [LifeW-1:0] in_life, in_elapsed;
    assign in_slot    = s_axis_tdata[5:0];
    assign in_vx      = s_axis_tdata[19:6];
    assign in_vy      = s_axis_tdata[33:20];
    assign in_life    = s_axis_tdata[53:34];
    assign in_elapsed = s_axis_tdata[73:54];

    logic in_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // particle RAM
    logic ram_we;
    logic [AW-1:0] ram_waddr, r_idx;
    logic [EntryW-1:0] ram_wdata, ram_rdata;
    pbu_ram #(.WIDTH(EntryW), .DEPTH(NUM_PARTICLES)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(r_idx), .o_rdata(ram_rdata)
    );

    logic [NUM_PARTICLES-1:0] r_alive;
    logic [LifeW-1:0] r_elapsed, r_life;
    logic signed [PosW-1:0] r_px, r_py;
    logic signed [VelW-1:0] r_vx, r_vy;
    logic r_live;

    logic [LifeW-1:0] rd_life;
    logic rd_live;
    assign rd_life = ram_rdata[EntryW-1 -: LifeW];
    assign rd_live = r_alive[r_idx] && (rd_life > r_elapsed);

    // shared restoring divider: unsigned magnitude / divisor
    logic [DivW-1:0] r_num, r_den, r_quo, r_rem;
    logic [5:0] r_cnt;
    logic signed [ProdW-1:0] r_prod;
    logic [DivW:0] rem_sh;
    assign rem_sh = {r_rem, r_num[DivW-1]};

    // divide |vel * elapsed| by one million: drop 2^6, multiply by 1/15625
    logic [ProdW-1:0] prod_mag;
    logic [54:0] r_rmul;
    assign prod_mag = r_prod[ProdW-1] ? ProdW'(-r_prod) : ProdW'(r_prod);

    // square root, two bits a step
    logic [41:0] r_sq;
    logic [21:0] r_root;
    logic [23:0] r_srem;
    logic [23:0] s_trial;
    logic [23:0] s_rsh;
    assign s_rsh   = {r_srem[21:0], r_sq[41:40]};
    assign s_trial = {r_root, 2'b01};

    logic [GradW-1:0] r_gu, r_gv;
    logic signed [PosW+1:0] dxy;

    // output register
    logic r_ovalid, r_olast;
    logic [71:0] r_odata;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    logic signed [PosW+1:0] sum;
    logic signed [ProdW-1:0] quo_s;
    logic signed [PosW-1:0] sat;
    always_comb begin
        quo_s = r_prod[ProdW-1] ? -ProdW'(r_rmul[54:41]) : ProdW'(r_rmul[54:41]);
        sum = ((r_state == S_DIVX) ? (PosW+2)'(r_px) : (PosW+2)'(r_py)) + (PosW+2)'(quo_s);
        if (sum > (PosW+2)'(524287)) sat = PosW'(524287);
        else if (sum < -(PosW+2)'(524288)) sat = -PosW'(524288);
        else sat = sum[PosW-1:0];
    end
    assign dxy = (r_state == S_SQR) ? ((PosW+2)'(r_px) - (PosW+2)'(r_emit_x)) : '0;

    logic [1:0] r_sqph;
    logic [2*PosW+1:0] r_acc;
    logic signed [PosW+1:0] dy_w;
    assign dy_w = (PosW+2)'(r_py) - (PosW+2)'(r_emit_y);

    logic div_busy;
    assign div_busy = (r_cnt != 0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc && s_axis_tuser == ReqTick) n_state = S_READ;
            S_READ: n_state = S_LIFE;
            S_LIFE: n_state = rd_live ? S_MULX : S_EMIT;
            S_MULX: n_state = S_DIVX;
            S_DIVX: n_state = S_MULY;
            S_MULY: n_state = S_DIVY;
            S_DIVY: n_state = S_SQR;
            S_SQR:  if (r_sqph == 2'd2) n_state = S_ISQ;
            S_ISQ:  if (r_cnt == 0) n_state = S_DIVU;
            S_DIVU: if (!div_busy) n_state = S_DIVV;
            S_DIVV: if (!div_busy) n_state = S_EMIT;
            S_EMIT: if (!r_ovalid || m_axis_tready)
                        n_state = (r_idx == AW'(NUM_PARTICLES-1)) ? S_IDLE : S_READ;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // RAM write: load or writeback of live particle
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {r_life, r_vy, r_vx, r_py, r_px};
        if (r_state == S_IDLE && in_acc && s_axis_tuser == ReqLoad
            && 32'(in_slot) < NUM_PARTICLES) begin
            ram_we = 1'b1;
            ram_waddr = in_slot[AW-1:0];
            ram_wdata = {in_life, in_vy, in_vx, r_emit_y, r_emit_x};
        end else if (r_state == S_EMIT && r_live && n_state != S_EMIT) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive  <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_state == S_EMIT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            // divider step
            if (div_busy && r_state != S_ISQ) begin
                r_num <= {r_num[DivW-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= DivW'(rem_sh - {1'b0, r_den});
                    r_quo <= {r_quo[DivW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[DivW-1:0];
                    r_quo <= {r_quo[DivW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && s_axis_tuser == ReqLoad && 32'(in_slot) < NUM_PARTICLES)
                        r_alive[in_slot[AW-1:0]] <= 1'b1;
                    if (in_acc && s_axis_tuser == ReqTick) begin
                        r_elapsed <= in_elapsed;
                        r_idx <= '0;
                    end
                end
                S_LIFE: begin
                    {r_vy, r_vx, r_py, r_px} <= ram_rdata[EntryW-LifeW-1:0];
                    // only a live slot uses the decremented life
                    r_life <= rd_life - r_elapsed;
                    r_live <= rd_live;
                    r_gu <= '0; r_gv <= '0;
                    if (!rd_live) r_alive[r_idx] <= 1'b0;
                    r_prod <= ProdW'($signed(ram_rdata[PosW*2 +: VelW]))
                              * $signed({1'b0, r_elapsed});
                end
                S_MULX, S_MULY: begin
                    // magnitude stays below 2^33
                    r_rmul <= 55'(prod_mag[32:6]) * 55'(RecipM);
                end
                S_DIVX: begin
                    r_px <= sat;
                    r_prod <= ProdW'(r_vy) * $signed({1'b0, r_elapsed});
                end
                S_DIVY: begin
                    r_py <= sat;
                    r_sqph <= '0;
                end
                S_SQR: begin
                    // dx*dx, then add dy*dy
                    case (r_sqph)
                        2'd0: r_acc <= (2*PosW+2)'($signed(dxy) * $signed(dxy));
                        2'd1: r_acc <= r_acc + (2*PosW+2)'($signed(dy_w) * $signed(dy_w));
                        default: begin
                            r_sq <= r_acc[41:0];
                            r_root <= '0; r_srem <= '0;
                            r_cnt <= 6'd21;
                        end
                    endcase
                    r_sqph <= r_sqph + 2'd1;
                end
                S_ISQ: begin
                    if (r_cnt != 0) begin
                        r_sq <= {r_sq[39:0], 2'b00};
                        if (s_rsh >= s_trial) begin
                            r_srem <= s_rsh - s_trial;
                            r_root <= {r_root[20:0], 1'b1};
                        end else begin
                            r_srem <= s_rsh;
                            r_root <= {r_root[20:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 6'd1;
                    end else begin
                        r_num <= DivW'(r_life) * DivW'(2000);
                        r_den <= (r_full == '0) ? DivW'(1) : DivW'(r_full);
                        r_rem <= '0; r_quo <= '0; r_cnt <= 6'(DivW);
                    end
                end
                S_DIVU: if (!div_busy) begin
                    r_gu <= (r_quo > DivW'(511)) ? GradW'(511) : r_quo[GradW-1:0];
                    r_num <= DivW'({r_root, 5'b0});
                    r_den <= (r_maxd == '0) ? DivW'(1) : DivW'(r_maxd);
                    r_rem <= '0; r_quo <= '0; r_cnt <= 6'(DivW);
                end
                S_DIVV: if (!div_busy) begin
                    if (r_quo >= DivW'(512)) r_gv <= '0;
                    else if (r_quo == '0) r_gv <= GradW'(511);
                    else r_gv <= GradW'(DivW'(512) - r_quo);
                end
                S_EMIT: if (!r_ovalid || m_axis_tready) begin
                    r_olast <= (r_idx == AW'(NUM_PARTICLES-1));
                    r_odata <= {7'b0, (r_live ? r_gv : '0), (r_live ? r_gu : '0),
                                (r_live ? r_py : '0), (r_live ? r_px : '0), r_live,
                                6'(r_idx)};
                    if (r_idx != AW'(NUM_PARTICLES-1)) r_idx <= r_idx + AW'(1);
                end
                default: ;
            endcase
        end
    end

    // result words only leave while walking a tick
    a_out_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_EMIT)) else $error("stray result");
    // no input taken while a tick is in progress
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule

// ===== verif/tb_particle_burst_update.sv =====
`timescale 1ns / 1ps
// Testbench for particle_burst_update: drives load and tick words, predicts the
// per-slot results of every tick and checks them. Depends on pbu_pkg and particle_burst_update.
module tb_particle_burst_update;
    import pbu_pkg::*;

    localparam int NSLOT    = 64;
    localparam int WDOG_MAX = 40000;
    localparam int HOLD_LEN = 1500;

    typedef struct {
        logic                     kind;
        logic [5:0]               slot;
        logic signed [VelW-1:0]   vx;
        logic signed [VelW-1:0]   vy;
        logic [LifeW-1:0]         life;
        logic [LifeW-1:0]         elapsed;
        bit                       drain;
    } t_word;

    typedef struct {
        logic [5:0]             slot;
        logic                   alive;
        logic signed [PosW-1:0] px;
        logic signed [PosW-1:0] py;
        logic [GradW-1:0]       gu;
        logic [GradW-1:0]       gv;
        logic                   last;
    } t_slot_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [79:0]         s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [71:0]         m_axis_tdata;
    logic                m_axis_tlast;

    particle_burst_update u_top (.*);

    always #5 i_clk = ~i_clk;

    // predicted copy of the particle table and registers
    logic signed [PosW-1:0] emit_x, emit_y;
    logic [FullW-1:0]       full_life;
    logic [MaxdW-1:0]       max_dist;
    logic signed [PosW-1:0] tbl_px [NSLOT];
    logic signed [PosW-1:0] tbl_py [NSLOT];
    logic signed [VelW-1:0] tbl_vx [NSLOT];
    logic signed [VelW-1:0] tbl_vy [NSLOT];
    logic [LifeW-1:0]       tbl_life [NSLOT];
    bit                     tbl_alive [NSLOT];

    t_word     load_q[$];
    t_slot_res exp_q[$];
    int        n_err = 0;
    int        n_res = 0;
    bit        in_taken = 0;
    bit        no_idle = 0;
    bit        hold_done = 0;
    int        wdog = 0;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [PosW-1:0] integrate(logic signed [PosW-1:0] p,
                                                         logic signed [VelW-1:0] v,
                                                         logic [LifeW-1:0] dt);
        longint prod, step, sum;
        prod = longint'(v) * longint'(dt);
        step = (prod < 0) ? -((-prod) / 1000000) : prod / 1000000;
        sum  = longint'(p) + step;
        if (sum > 524287) sum = 524287;
        if (sum < -524288) sum = -524288;
        return sum[PosW-1:0];
    endfunction

    // apply one accepted word to the table; a tick queues 64 slot results
    task automatic apply_word(t_word w);
        t_slot_res r;
        longint unsigned fl, md, u, d, t;
        longint dx, dy;
        if (w.kind == ReqLoad) begin
            tbl_px[w.slot] = emit_x;
            tbl_py[w.slot] = emit_y;
            tbl_vx[w.slot] = w.vx;
            tbl_vy[w.slot] = w.vy;
            tbl_life[w.slot] = w.life;
            tbl_alive[w.slot] = 1;
            return;
        end
        fl = (full_life == 0) ? 1 : full_life;
        md = (max_dist == 0) ? 1 : max_dist;
        for (int i = 0; i < NSLOT; i++) begin
            r = '{slot: i[5:0], alive: 0, px: '0, py: '0, gu: '0, gv: '0,
                  last: (i == NSLOT-1)};
            if (tbl_alive[i]) begin
                if (tbl_life[i] <= w.elapsed) begin
                    tbl_life[i] = '0;
                    tbl_alive[i] = 0;
                end else begin
                    tbl_life[i] -= w.elapsed;
                    r.alive = 1;
                end
            end
            if (r.alive) begin
                tbl_px[i] = integrate(tbl_px[i], tbl_vx[i], w.elapsed);
                tbl_py[i] = integrate(tbl_py[i], tbl_vy[i], w.elapsed);
                r.px = tbl_px[i];
                r.py = tbl_py[i];
                u = (64'd2000 * tbl_life[i]) / fl;
                r.gu = (u > 511) ? 9'd511 : u[8:0];
                dx = longint'(tbl_px[i]) - longint'(emit_x);
                dy = longint'(tbl_py[i]) - longint'(emit_y);
                d = int_sqrt(dx * dx + dy * dy);
                t = (32 * d) / md;
                r.gv = (t >= 512) ? 9'd0 : ((t == 0) ? 9'd511 : 9'(512 - t));
            end
            exp_q.push_back(r);
        end
    endtask

    // input side: present queued words with random gaps
    int in_gap = 0;
    always @(negedge i_clk) begin
        t_word w;
        logic  nv;
        if (i_rst_n) begin
            nv = s_axis_tvalid;
            if (!s_axis_tvalid || in_taken) begin
                in_taken = 0;
                nv = 1'b0;
                if (in_gap > 0) begin
                    in_gap--;
                end else if (load_q.size() != 0 &&
                             (!load_q[0].drain || exp_q.size() == 0)) begin
                    w = load_q.pop_front();
                    s_axis_tdata <= {6'd0, w.elapsed, w.life, w.vy, w.vx, w.slot};
                    s_axis_tuser <= w.kind;
                    nv = 1'b1;
                    in_gap = no_idle ? 0 : $urandom_range(0, 15);
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // output side: random stalls plus one long hold-off
    int out_gap = 0;
    int hold_cnt = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && n_res >= 600) begin
                hold_done = 1;
                hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor, predictor hookup and watchdog
    always @(posedge i_clk) begin
        t_slot_res e;
        if (i_rst_n) begin
            wdog++;
            if (s_axis_tvalid && s_axis_tready) begin
                t_word w;
                w.kind = s_axis_tuser;
                {w.elapsed, w.life, w.vy, w.vx, w.slot} = s_axis_tdata[73:0];
                w.drain = 0;
                apply_word(w);
                in_taken = 1;
                wdog = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                wdog = 0;
                n_res++;
                if (m_axis_tready && out_gap == 0)
                    out_gap = no_idle ? 0 : $urandom_range(0, 15);
                if (exp_q.size() == 0) begin
                    $error("unexpected result word, slot %0d", m_axis_tdata[5:0]);
                    n_err++;
                end else begin
                    e = exp_q.pop_front();
                    if (m_axis_tdata[5:0] !== e.slot) begin
                        $error("out_slot exp %0d got %0d", e.slot, m_axis_tdata[5:0]);
                        n_err++;
                    end
                    if (m_axis_tdata[6] !== e.alive) begin
                        $error("alive exp %0d got %0d", e.alive, m_axis_tdata[6]);
                        n_err++;
                    end
                    if (m_axis_tdata[26:7] !== e.px) begin
                        $error("pos_x exp %0d got %0d", e.px, $signed(m_axis_tdata[26:7]));
                        n_err++;
                    end
                    if (m_axis_tdata[46:27] !== e.py) begin
                        $error("pos_y exp %0d got %0d", e.py, $signed(m_axis_tdata[46:27]));
                        n_err++;
                    end
                    if (m_axis_tdata[55:47] !== e.gu) begin
                        $error("grad_u exp %0d got %0d", e.gu, m_axis_tdata[55:47]);
                        n_err++;
                    end
                    if (m_axis_tdata[64:56] !== e.gv) begin
                        $error("grad_v exp %0d got %0d", e.gv, m_axis_tdata[64:56]);
                        n_err++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_axis_tlast);
                        n_err++;
                    end
                end
            end
            if (wdog >= WDOG_MAX) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            RegEmitX: emit_x = val[PosW-1:0];
            RegEmitY: emit_y = val[PosW-1:0];
            RegFull:  full_life = val[FullW-1:0];
            RegMaxd:  max_dist = val[MaxdW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        wdog = 0;
    endtask

    // let queued words drain, then let the block settle before a write
    task automatic settle();
        wait (load_q.size() == 0 && !s_axis_tvalid);
        wait (exp_q.size() == 0);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic t_word mk_load(int s, int vx, int vy, int life);
        t_word w = '{kind: ReqLoad, slot: s[5:0], vx: vx[VelW-1:0], vy: vy[VelW-1:0],
                     life: life[LifeW-1:0], elapsed: LifeW'($urandom), drain: 0};
        return w;
    endfunction

    function automatic t_word mk_tick(int dt);
        t_word w = '{kind: ReqTick, slot: 6'($urandom), vx: VelW'($urandom),
                     vy: VelW'($urandom), life: LifeW'($urandom),
                     elapsed: dt[LifeW-1:0], drain: 0};
        return w;
    endfunction

    function automatic t_word rand_word();
        if ($urandom_range(0, 6) == 0)
            return mk_tick(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 150000));
        return mk_load($urandom_range(0, 63), $urandom, $urandom,
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(200000, 1048575));
    endfunction

    initial begin
        t_word w;
        emit_x = '0;
        emit_y = '0;
        full_life = 3000000;
        max_dist = 150;
        foreach (tbl_alive[i]) tbl_alive[i] = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: zero life, extreme velocities and lives, ticks of 0, 1 and 700000
        load_q.push_back(mk_load(0, 0, 0, 0));
        load_q.push_back(mk_load(63, 8191, -8192, 1048575));
        load_q.push_back(mk_load(31, -8192, 8191, 1048575));
        load_q.push_back(mk_load(5, -1, 1, 1));
        load_q.push_back(mk_tick(0));
        load_q.push_back(mk_tick(1));
        load_q.push_back(mk_tick(700000));
        settle();

        // extremes: emitter at a corner, smallest divisors
        cfg_write(RegEmitX, 22'h07FFFF);
        cfg_write(RegEmitY, 22'h080000);
        cfg_write(RegFull, 22'd1);
        cfg_write(RegMaxd, 22'd1);
        load_q.push_back(mk_load(0, 8191, -8192, 1048575));
        load_q.push_back(mk_load(1, -8192, 8191, 1048575));
        load_q.push_back(mk_load(2, 8191, 8191, 1048575));
        load_q.push_back(mk_tick(1048575));
        load_q.push_back(mk_load(3, 0, 0, 1048575));
        load_q.push_back(mk_tick(1000));
        settle();

        // zero divisors count as one, largest lifetime then
        cfg_write(RegFull, 22'd0);
        cfg_write(RegMaxd, 22'd0);
        load_q.push_back(mk_load(10, 100, -100, 500000));
        load_q.push_back(mk_tick(2000));
        settle();
        cfg_write(RegFull, 22'h3FFFFF);
        cfg_write(RegMaxd, 22'hFFFF);
        cfg_write(RegEmitX, 22'h080000);
        cfg_write(RegEmitY, 22'h07FFFF);
        load_q.push_back(mk_load(20, -8192, 8191, 1048575));
        load_q.push_back(mk_tick(1048575));
        load_q.push_back(mk_tick(1));
        settle();

        // random phases with varied register settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    cfg_write(RegEmitX, 22'd0);
                    cfg_write(RegEmitY, 22'd0);
                    cfg_write(RegFull, 22'd3000000);
                    cfg_write(RegMaxd, 22'd150);
                end
                default: begin
                    cfg_write(RegEmitX, 22'($urandom));
                    cfg_write(RegEmitY, 22'($urandom));
                    cfg_write(RegFull, 22'($urandom_range(1, 4194303)));
                    cfg_write(RegMaxd, 22'($urandom_range(1, 2000)));
                end
            endcase
            no_idle = (ph == 2);
            for (int k = 0; k < 80; k++) begin
                w = rand_word();
                w.drain = (ph == 1 && k == 40);
                load_q.push_back(w);
            end
            load_q.push_back(mk_tick($urandom_range(0, 100000)));
            settle();
        end

        if (n_err == 0 && exp_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/pbu_pkg.sv
hdl/pbu_ram.sv
hdl/particle_burst_update.sv
verif/tb_particle_burst_update.sv
